// ----- src/fpmul_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmul_pkg
// Shared types and constants of the single-precision multiplier.
// ----------------------------------------------------------------------------
package fpmul_pkg;

  localparam int unsigned FracBits   = 23;
  localparam int unsigned SigBits    = 24;
  localparam int unsigned ProdBits   = 48;
  localparam int unsigned StickyBits = 20;
  localparam int unsigned ExpBias    = 127;
  localparam int unsigned NumCells   = 24;

  localparam logic [1:0] RangeOk    = 2'd0;
  localparam logic [1:0] RangeOver  = 2'd1;
  localparam logic [1:0] RangeUnder = 2'd2;

  typedef struct packed {
    logic                sign;
    logic [9:0]          exp_sum;
    logic [SigBits-1:0]  mcand;
    logic [SigBits-1:0]  mplier;
    logic [ProdBits-1:0] acc;
  } cell_data_t;

  typedef struct packed {
    logic                sign;
    logic [7:0]          exponent;
    logic [FracBits-1:0] fraction;
    logic [1:0]          range_error;
  } result_t;

endpackage

// ----- src/fpmul_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmul_cell
// One shift-and-add cell: adds the shifted multiplicand for one multiplier bit.
// ----------------------------------------------------------------------------
module fpmul_cell #(
  parameter int unsigned BitIdx = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  fpmul_pkg::cell_data_t  data_i,
  output logic                   valid_o,
  output fpmul_pkg::cell_data_t  data_o
);
  import fpmul_pkg::*;

  logic       valid_q;
  cell_data_t data_q, data_d;

  always_comb begin
    data_d = data_i;
    if (data_i.mplier[BitIdx]) begin
      data_d.acc = data_i.acc + ({{SigBits{1'b0}}, data_i.mcand} << BitIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ----- src/fpmul_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmul_round
// Normalizes and rounds the product to nearest-even and checks the range.
// ----------------------------------------------------------------------------
module fpmul_round (
  input  fpmul_pkg::cell_data_t data_i,
  output fpmul_pkg::result_t    res_o
);
  import fpmul_pkg::*;

  logic [27:0]        word;
  logic               hi;
  logic [24:0]        keep;
  logic [3:0]         rem;
  logic               up;
  logic [24:0]        rnd;
  logic [23:0]        sig;
  logic signed [10:0] ex;

  always_comb begin
    word = {data_i.acc[ProdBits-1:StickyBits+1],
            data_i.acc[StickyBits] | (|data_i.acc[StickyBits-1:0])};
    hi = word[27];
    if (hi) begin
      keep = {1'b0, word[27:4]};
      rem  = word[3:0];
      up   = (rem > 4'd8) || ((rem == 4'd8) && word[4]);
    end else begin
      keep = {1'b0, word[26:3]};
      rem  = {1'b0, word[2:0]};
      up   = (rem > 4'd4) || ((rem == 4'd4) && word[3]);
    end
    rnd = keep + {24'd0, up};
    ex  = $signed({1'b0, data_i.exp_sum}) - 11'sd127 + $signed({10'd0, hi});
    if (rnd[24]) begin
      sig = rnd[24:1];
      ex  = ex + 11'sd1;
    end else begin
      sig = rnd[23:0];
    end
    res_o.sign = data_i.sign;
    if (ex >= 11'sd255) begin
      res_o.exponent    = '0;
      res_o.fraction    = '0;
      res_o.range_error = RangeOver;
    end else if (ex <= 11'sd0) begin
      res_o.exponent    = '0;
      res_o.fraction    = '0;
      res_o.range_error = RangeUnder;
    end else begin
      res_o.exponent    = ex[7:0];
      res_o.fraction    = sig[FracBits-1:0];
      res_o.range_error = RangeOk;
    end
  end
endmodule

// ----- src/fp32_multiplier_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp32_multiplier_unit
// Single-precision multiplier for normal operands, round to nearest-even.
// ----------------------------------------------------------------------------
// Operands arrive on the s_axis channel and products leave on m_axis, one
// product per operand transfer, in order.
// The significand product is built by a row of 24 shift-and-add cells, one
// per multiplier bit, followed by a round stage and an output register.
// A product is registered in each cell and then in the output register.
// Throughput is one operand pair per cycle while not stalled; the pipeline is full-rate.
// The whole pipeline holds only when the output register is full and
// m_axis_tready is low, and s_axis_tready drops only in that case.
// Reset clears all valid bits; the pipeline is then empty and ready.
// Operands with exponent 0 or 255 are treated as normal numbers.
// ----------------------------------------------------------------------------
module fp32_multiplier_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // a_sign[0], a_exponent[8:1], a_fraction[31:9], b_sign[32],
  // b_exponent[40:33], b_fraction[63:41]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // prod_sign[0], prod_exponent[8:1], prod_fraction[31:9], range_error[33:32]
  output logic [39:0] m_axis_tdata
);
  import fpmul_pkg::*;

  logic                en;
  logic [NumCells:0]   valid;
  cell_data_t          data [NumCells+1];
  result_t             res;
  logic                out_valid_q;
  result_t             out_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  assign valid[0]        = s_axis_tvalid;
  assign data[0].sign    = s_axis_tdata[0] ^ s_axis_tdata[32];
  assign data[0].exp_sum = {2'b0, s_axis_tdata[8:1]} + {2'b0, s_axis_tdata[40:33]};
  assign data[0].mcand   = {1'b1, s_axis_tdata[63:41]};
  assign data[0].mplier  = {1'b1, s_axis_tdata[31:9]};
  assign data[0].acc     = '0;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    fpmul_cell #(.BitIdx(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid[g]),
      .data_i  (data[g]),
      .valid_o (valid[g+1]),
      .data_o  (data[g+1])
    );
  end

  fpmul_round u_round (
    .data_i (data[NumCells]),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.range_error, out_q.fraction, out_q.exponent, out_q.sign};
endmodule
